/* src/grce_pkg.sv */
`default_nettype none

package grce_pkg;

  // Field widths
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PixW    = 32;
  localparam int unsigned ColW    = 9;
  localparam int unsigned RowW    = 8;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned GLineW  = 5;
  localparam int unsigned GBitsW  = 8;
  localparam int unsigned NumPix  = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_FB_BASE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FB_PITCH    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FB_WIDTH    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FB_HEIGHT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_DEPTH = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FONT_HEIGHT = 3'd5;

  // Register reset values
  localparam logic [31:0] FB_BASE_RST     = 32'd0;
  localparam logic [15:0] FB_PITCH_RST    = 16'd2560;
  localparam logic [11:0] FB_WIDTH_RST    = 12'd640;
  localparam logic [11:0] FB_HEIGHT_RST   = 12'd480;
  localparam logic [5:0]  PIXEL_DEPTH_RST = 6'd32;
  localparam logic [5:0]  FONT_HEIGHT_RST = 6'd16;

  // Supported depths
  localparam logic [5:0] DEPTH_8  = 6'd8;
  localparam logic [5:0] DEPTH_16 = 6'd16;
  localparam logic [5:0] DEPTH_24 = 6'd24;
  localparam logic [5:0] DEPTH_32 = 6'd32;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Parameter defaults
  localparam int unsigned MAX_FONT_HEIGHT_DEF = 32;
  localparam int unsigned GLYPH_COUNT_DEF     = 256;

  // Multiplier operand width
  localparam int unsigned MulW = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ROW,
    ST_CHECK,
    ST_MUL_COL,
    ST_SUM,
    ST_ROW
  } state_e;

  function automatic logic [PixW-1:0] depth_mask(input logic [5:0] depth);
    logic [PixW-1:0] m;
    case (depth)
      DEPTH_8:  m = 32'h0000_00ff;
      DEPTH_16: m = 32'h0000_ffff;
      DEPTH_24: m = 32'h00ff_ffff;
      default:  m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* src/grce_if.sv */
`default_nettype none

interface grce_in_if import grce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ColW-1:0]   cell_column;
  logic [RowW-1:0]   cell_row;
  logic [CodeW-1:0]  char_code;
  logic [GLineW-1:0] glyph_line;
  logic [GBitsW-1:0] glyph_bits;
  logic [PixW-1:0]   fg_color;
  logic [PixW-1:0]   bg_color;

  modport source (
    output valid, opcode, cell_column, cell_row, char_code, glyph_line, glyph_bits,
           fg_color, bg_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, cell_column, cell_row, char_code, glyph_line, glyph_bits,
           fg_color, bg_color,
    output ready
  );
endinterface

interface grce_out_if import grce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] row_address;
  logic [PixW-1:0]  pixel_0;
  logic [PixW-1:0]  pixel_1;
  logic [PixW-1:0]  pixel_2;
  logic [PixW-1:0]  pixel_3;
  logic [PixW-1:0]  pixel_4;
  logic [PixW-1:0]  pixel_5;
  logic [PixW-1:0]  pixel_6;
  logic [PixW-1:0]  pixel_7;
  logic             last_row;

  modport source (
    output valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
           pixel_6, pixel_7, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
           pixel_6, pixel_7, last_row,
    output ready
  );
endinterface

`default_nettype wire

/* src/glyph_row_color_expander_core.sv */
// Load item: stored on accept when its code and line are in range, ready
// again the next cycle; no result. Draw item: one shared 16x16 multiplier
// forms the start address in the steps MUL_ROW, CHECK, MUL_COL and SUM, then
// one row per cycle leaves through the output register while the output is
// not stalled. A draw rejected at accept or on the row bound gives no rows.
// Reset clears control state and config registers; the glyph store is not cleared.
`default_nettype none

module glyph_row_color_expander_core import grce_pkg::*; #(
  parameter int unsigned MAX_FONT_HEIGHT = MAX_FONT_HEIGHT_DEF,
  parameter int unsigned GLYPH_COUNT     = GLYPH_COUNT_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  grce_in_if.sink             in_i,
  grce_out_if.source          out_o
);

  localparam int unsigned Depth = GLYPH_COUNT * MAX_FONT_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned HW    = $clog2(MAX_FONT_HEIGHT + 1);
  localparam int unsigned LW    = (MAX_FONT_HEIGHT > 1) ? $clog2(MAX_FONT_HEIGHT) : 1;

  // Configuration registers
  logic [31:0] fb_base_q;
  logic [15:0] fb_pitch_q;
  logic [11:0] fb_width_q;
  logic [11:0] fb_height_q;
  logic [5:0]  pixel_depth_q;
  logic [5:0]  font_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q     <= FB_BASE_RST;
      fb_pitch_q    <= FB_PITCH_RST;
      fb_width_q    <= FB_WIDTH_RST;
      fb_height_q   <= FB_HEIGHT_RST;
      pixel_depth_q <= PIXEL_DEPTH_RST;
      font_height_q <= FONT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FB_BASE:     fb_base_q     <= cfg_data_i;
        CFG_FB_PITCH:    fb_pitch_q    <= cfg_data_i[15:0];
        CFG_FB_WIDTH:    fb_width_q    <= cfg_data_i[11:0];
        CFG_FB_HEIGHT:   fb_height_q   <= cfg_data_i[11:0];
        CFG_PIXEL_DEPTH: pixel_depth_q <= cfg_data_i[5:0];
        CFG_FONT_HEIGHT: font_height_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [HW-1:0]    h_q, h_d;
  logic [LW-1:0]    line_q, line_d;
  logic [AW-1:0]    code_base_q, code_base_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [PixW-1:0]  fg_q, fg_d, bg_q, bg_d;
  logic [31:0]      prod_q, prod_d;
  logic [AddrW-1:0] acc_q, acc_d;

  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] out_addr_q;
  logic [PixW-1:0]  out_pix_q [NumPix];
  logic             out_last_q;

  logic [7:0]       rdata_q;

  logic             in_acc;
  logic             draw_ok;
  logic             load_we;
  logic [AW-1:0]    load_addr;
  logic [AW-1:0]    rd_addr;
  logic [HW-1:0]    h_eff;
  logic             depth_ok;
  logic             slot_free;
  logic             issue;
  logic             last;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [31:0]      mul_p;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign last       = ((HW'(line_q) + HW'(1)) == h_q);
  assign issue      = (state_q == ST_ROW) && slot_free;

  assign h_eff = (int'(font_height_q) > int'(MAX_FONT_HEIGHT)) ?
                 HW'(MAX_FONT_HEIGHT) : HW'(font_height_q);

  assign depth_ok = (pixel_depth_q == DEPTH_8) || (pixel_depth_q == DEPTH_16) ||
                    (pixel_depth_q == DEPTH_24) || (pixel_depth_q == DEPTH_32);

  // Column bound and code checks are cheap; the row bound needs the multiplier
  assign draw_ok = depth_ok && (h_eff != '0) &&
                   (32'(in_i.char_code) < 32'(GLYPH_COUNT)) &&
                   ((13'(in_i.cell_column) + 13'd1) * 13'd8 <= 13'(fb_width_q));

  assign load_we = in_acc && (in_i.opcode == OP_LOAD) &&
                   (32'(in_i.char_code) < 32'(GLYPH_COUNT)) &&
                   (32'(in_i.glyph_line) < 32'(MAX_FONT_HEIGHT));

  assign load_addr = AW'(32'(in_i.char_code) * 32'(MAX_FONT_HEIGHT) + 32'(in_i.glyph_line));
  assign rd_addr   = code_base_q + AW'(line_d);

  // Shared multiplier: operands chosen by the sequencer step
  always_comb begin
    case (state_q)
      ST_MUL_ROW: begin
        mul_a = MulW'(row_q) + MulW'(1);
        mul_b = MulW'(h_q);
      end
      ST_CHECK: begin
        mul_a = fb_pitch_q;
        mul_b = MulW'(prod_q - 32'(h_q));
      end
      ST_MUL_COL: begin
        mul_a = MulW'(pixel_depth_q);
        mul_b = MulW'(col_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 32'(mul_a) * 32'(mul_b);
  end

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    line_d      = '0;
    code_base_d = code_base_q;
    col_d       = col_q;
    row_d       = row_q;
    fg_d        = fg_q;
    bg_d        = bg_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.opcode == OP_DRAW) && draw_ok) begin
          state_d     = ST_MUL_ROW;
          h_d         = h_eff;
          code_base_d = AW'(32'(in_i.char_code) * 32'(MAX_FONT_HEIGHT));
          col_d       = in_i.cell_column;
          row_d       = in_i.cell_row;
          fg_d        = in_i.fg_color & depth_mask(pixel_depth_q);
          bg_d        = in_i.bg_color & depth_mask(pixel_depth_q);
        end
      end
      ST_MUL_ROW: begin
        prod_d  = mul_p;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // Drop the draw when the cell's last pixel row falls below the frame
        if (prod_q > 32'(fb_height_q)) begin
          state_d = ST_IDLE;
        end else begin
          prod_d  = mul_p;
          acc_d   = fb_base_q;
          state_d = ST_MUL_COL;
        end
      end
      ST_MUL_COL: begin
        acc_d   = acc_q + prod_q;
        prod_d  = mul_p;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = acc_q + prod_q;
        state_d = ST_ROW;
      end
      ST_ROW: begin
        line_d = line_q;
        if (issue) begin
          out_valid_d = 1'b1;
          if (last) begin
            line_d  = '0;
            state_d = ST_IDLE;
          end else begin
            line_d = line_q + LW'(1);
            acc_d  = acc_q + AddrW'(fb_pitch_q);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q         <= h_d;
    code_base_q <= code_base_d;
    col_q       <= col_d;
    row_q       <= row_d;
    fg_q        <= fg_d;
    bg_q        <= bg_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    if (issue) begin
      out_addr_q <= acc_q;
      out_last_q <= last;
      for (int k = 0; k < NumPix; k++) begin
        out_pix_q[k] <= rdata_q[NumPix-1-k] ? fg_q : bg_q;
      end
    end
  end

  // Glyph store
  logic [GBitsW-1:0] glyph_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      glyph_mem[load_addr] <= in_i.glyph_bits;
    end
    rdata_q <= glyph_mem[rd_addr];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.row_address = out_addr_q;
  assign out_o.pixel_0     = out_pix_q[0];
  assign out_o.pixel_1     = out_pix_q[1];
  assign out_o.pixel_2     = out_pix_q[2];
  assign out_o.pixel_3     = out_pix_q[3];
  assign out_o.pixel_4     = out_pix_q[4];
  assign out_o.pixel_5     = out_pix_q[5];
  assign out_o.pixel_6     = out_pix_q[6];
  assign out_o.pixel_7     = out_pix_q[7];
  assign out_o.last_row    = out_last_q;

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW) |-> (HW'(line_q) < h_q))
    else $error("row counter beyond glyph height");

  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.opcode == OP_LOAD)) |=> (state_q == ST_IDLE))
    else $error("load left the sequencer busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last) |=> (out_o.valid && out_o.last_row && (state_q == ST_IDLE)))
    else $error("final row not flagged or draw not finished");

  a_row_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW && out_valid_q && !out_o.ready) |=> $stable(line_q))
    else $error("row advanced while output stalled");

endmodule

`default_nettype wire

/* tb/glyph_row_color_expander_core_test.sv */
`timescale 1ns / 1ps

module glyph_row_color_expander_core_test;
  import grce_pkg::*;

  localparam int unsigned StoreDepth   = GLYPH_COUNT_DEF * MAX_FONT_HEIGHT_DEF;
  localparam int unsigned HoldAt       = 150;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned PhaseCount   = 10;

  typedef struct packed {
    logic              opcode;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [CodeW-1:0]  code;
    logic [GLineW-1:0] line;
    logic [GBitsW-1:0] bits;
    logic [PixW-1:0]   fg;
    logic [PixW-1:0]   bg;
  } cell_cmd_t;

  typedef struct packed {
    logic [AddrW-1:0]            addr;
    logic [NumPix-1:0][PixW-1:0] pix;
    logic                        last;
  } pixel_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  grce_in_if  cmd_if ();
  grce_out_if row_if ();

  glyph_row_color_expander_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (cmd_if),
    .out_o       (row_if)
  );

  always #5 clk_i = ~clk_i;

  // Register copies as the block should hold them
  logic [31:0] fb_base_q;
  logic [15:0] fb_pitch_q;
  logic [11:0] fb_width_q;
  logic [11:0] fb_height_q;
  logic [5:0]  depth_q;
  logic [5:0]  font_q;

  logic [GBitsW-1:0] glyph_mem [StoreDepth];
  bit                glyph_written [StoreDepth];

  cell_cmd_t   cmd_pending [$];
  pixel_row_t  rows_due [$];
  int unsigned items_taken;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  // Rows a draw produces under the current settings, zero when rejected
  function automatic int unsigned draw_height(cell_cmd_t c);
    int unsigned h;
    h = (font_q > MAX_FONT_HEIGHT_DEF) ? MAX_FONT_HEIGHT_DEF : font_q;
    case (depth_q)
      DEPTH_8, DEPTH_16, DEPTH_24, DEPTH_32: ;
      default: return 0;
    endcase
    if (c.code >= GLYPH_COUNT_DEF || h == 0) return 0;
    if ((c.row + 1) * h > fb_height_q) return 0;
    if ((c.col + 1) * 8 > fb_width_q) return 0;
    return h;
  endfunction

  function automatic void expand_cell(cell_cmd_t c);
    int unsigned h;
    int unsigned ln;
    logic [PixW-1:0] mask;
    logic [GBitsW-1:0] bits;
    pixel_row_t r;
    if (c.opcode == OP_LOAD) begin
      if (c.code < GLYPH_COUNT_DEF) glyph_mem[c.code * MAX_FONT_HEIGHT_DEF + c.line] = c.bits;
      return;
    end
    h = draw_height(c);
    case (depth_q)
      DEPTH_8:  mask = 32'h0000_00ff;
      DEPTH_16: mask = 32'h0000_ffff;
      DEPTH_24: mask = 32'h00ff_ffff;
      default:  mask = 32'hffff_ffff;
    endcase
    for (ln = 0; ln < h; ln++) begin
      bits = glyph_mem[c.code * MAX_FONT_HEIGHT_DEF + ln];
      r.addr = fb_base_q + 32'(fb_pitch_q) * (32'(c.row) * h + ln) + 32'(depth_q) * 32'(c.col);
      for (int k = 0; k < NumPix; k++) r.pix[k] = bits[7 - k] ? (c.fg & mask) : (c.bg & mask);
      r.last = (ln + 1 == h);
      rows_due.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportMax)
      $display("%0t: %s differs: expected %h, got %h", $time, what, want, got);
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic cell_cmd_t random_cmd();
    cell_cmd_t c;
    c.opcode = 1'($urandom_range(0, 1));
    c.col    = ColW'($urandom);
    c.row    = RowW'($urandom);
    c.code   = CodeW'($urandom);
    c.line   = GLineW'($urandom);
    c.bits   = GBitsW'($urandom);
    c.fg     = $urandom;
    c.bg     = $urandom;
    return c;
  endfunction

  function automatic cell_cmd_t cell_at(int unsigned col, int unsigned row,
                                        logic [CodeW-1:0] code,
                                        logic [PixW-1:0] fg, logic [PixW-1:0] bg);
    cell_cmd_t c;
    c = random_cmd();
    c.col  = ColW'(col);
    c.row  = RowW'(row);
    c.code = code;
    c.fg   = fg;
    c.bg   = bg;
    return c;
  endfunction

  function automatic void queue_cmd(cell_cmd_t c);
    if (c.opcode == OP_LOAD && c.code < GLYPH_COUNT_DEF)
      glyph_written[c.code * MAX_FONT_HEIGHT_DEF + c.line] = 1'b1;
    cmd_pending.push_back(c);
  endfunction

  function automatic void queue_load(logic [CodeW-1:0] code, logic [GLineW-1:0] line,
                                     logic [GBitsW-1:0] bits);
    cell_cmd_t c;
    c = random_cmd();
    c.opcode = OP_LOAD;
    c.code   = code;
    c.line   = line;
    c.bits   = bits;
    queue_cmd(c);
  endfunction

  // Load any glyph row the draw will read that was never written, then draw
  function automatic void queue_draw(cell_cmd_t c);
    int unsigned h;
    c.opcode = OP_DRAW;
    h = draw_height(c);
    for (int unsigned ln = 0; ln < h; ln++)
      if (!glyph_written[c.code * MAX_FONT_HEIGHT_DEF + ln])
        queue_load(c.code, GLineW'(ln), GBitsW'($urandom));
    queue_cmd(c);
  endfunction

  function automatic void queue_random_item();
    cell_cmd_t c;
    int unsigned h, cols_fit, rows_fit, pick;
    c = random_cmd();
    pick = $urandom_range(0, 99);
    h = (font_q > MAX_FONT_HEIGHT_DEF) ? MAX_FONT_HEIGHT_DEF : font_q;
    cols_fit = fb_width_q / 8;
    rows_fit = (h == 0) ? 0 : fb_height_q / h;
    if (cols_fit > 512) cols_fit = 512;
    if (rows_fit > 256) rows_fit = 256;
    if (pick < 20) begin
      // stray load, sometimes with a code past the store
      c.opcode = OP_LOAD;
      if (pick < 14) c.code = CodeW'($urandom_range(0, GLYPH_COUNT_DEF - 1));
      queue_cmd(c);
      return;
    end
    if ($urandom_range(0, 3) != 0) begin
      c.code = CodeW'($urandom_range(0, 8));
      if (c.code == 8) c.code = CodeW'(GLYPH_COUNT_DEF - 1);
    end else begin
      c.code = CodeW'($urandom_range(0, GLYPH_COUNT_DEF - 1));
    end
    if (pick >= 94) c.code = CodeW'($urandom_range(GLYPH_COUNT_DEF, 16'hffff));
    if (pick >= 26 && cols_fit != 0 && rows_fit != 0) begin
      c.col = ColW'($urandom_range(0, cols_fit - 1));
      c.row = RowW'($urandom_range(0, rows_fit - 1));
      if (pick >= 86 && pick < 90) begin
        c.col = ColW'(cols_fit - 1);
        c.row = RowW'(rows_fit - 1);
      end else if (pick >= 90 && pick < 94) begin
        // one cell past the frame edge
        if (cols_fit < 512 && pick[0]) c.col = ColW'(cols_fit);
        else if (rows_fit < 256) c.row = RowW'(rows_fit);
        else if (cols_fit < 512) c.col = ColW'(cols_fit);
      end
    end
    queue_draw(c);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_FB_BASE:     fb_base_q   = val;
      CFG_FB_PITCH:    fb_pitch_q  = val[15:0];
      CFG_FB_WIDTH:    fb_width_q  = val[11:0];
      CFG_FB_HEIGHT:   fb_height_q = val[11:0];
      CFG_PIXEL_DEPTH: depth_q     = val[5:0];
      CFG_FONT_HEIGHT: font_q      = val[5:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned phase);
    logic [31:0] base;
    logic [15:0] pitch;
    logic [11:0] wd, ht;
    logic [5:0]  dp, fh;
    base  = $urandom;
    pitch = 16'($urandom);
    wd    = 12'($urandom_range(8, 4095));
    ht    = 12'($urandom_range(1, 4095));
    fh    = 6'($urandom_range(1, 40));
    case ($urandom_range(0, 4))
      0:       dp = DEPTH_8;
      1:       dp = DEPTH_16;
      2:       dp = DEPTH_24;
      3:       dp = DEPTH_32;
      default: dp = 6'($urandom);
    endcase
    case (phase)
      1: begin
        base = 32'h0000_1000; pitch = 16'd320; wd = 12'd4095; ht = 12'd4095;
        dp = DEPTH_8; fh = 6'd8;
      end
      2: begin
        base = 32'hffff_fff0; pitch = 16'hffff; wd = 12'd2048; ht = 12'd4095;
        dp = DEPTH_16; fh = 6'd32;
      end
      3: begin
        dp = DEPTH_24; fh = 6'd63; wd = 12'd4095; ht = 12'd2000;
      end
      4: begin
        dp = 6'd12; fh = 6'd1;
      end
      5: begin
        dp = DEPTH_32; fh = 6'd0;
      end
      6: begin
        dp = 6'd63; fh = 6'd16; wd = 12'd0; ht = 12'd0;
      end
      7: begin
        // single cell frame
        base = 32'd0; pitch = 16'd0; wd = 12'd8; ht = 12'd1; dp = DEPTH_8; fh = 6'd1;
      end
      default: ;
    endcase
    // upper bits of the narrow registers carry junk
    write_reg(CFG_FB_BASE, base);
    write_reg(CFG_FB_PITCH, {16'($urandom), pitch});
    write_reg(CFG_FB_WIDTH, {20'($urandom), wd});
    write_reg(CFG_FB_HEIGHT, {20'($urandom), ht});
    write_reg(CFG_PIXEL_DEPTH, {26'($urandom), dp});
    write_reg(CFG_FONT_HEIGHT, {26'($urandom), fh});
  endtask

  task automatic drain();
    while (cmd_pending.size() != 0 || cmd_if.valid || rows_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------- sender ----------------

  int unsigned burst_left, gap_left;

  always @(posedge clk_i) begin : drive_proc
    cell_cmd_t taken, nxt;
    if (!rst_ni) begin
      cmd_if.valid       <= 1'b0;
      cmd_if.opcode      <= OP_LOAD;
      cmd_if.cell_column <= '0;
      cmd_if.cell_row    <= '0;
      cmd_if.char_code   <= '0;
      cmd_if.glyph_line  <= '0;
      cmd_if.glyph_bits  <= '0;
      cmd_if.fg_color    <= '0;
      cmd_if.bg_color    <= '0;
      burst_left         <= 0;
      gap_left           <= 0;
      items_taken        <= 0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (cmd_if.valid) begin
        taken.opcode = cmd_if.opcode;
        taken.col    = cmd_if.cell_column;
        taken.row    = cmd_if.cell_row;
        taken.code   = cmd_if.char_code;
        taken.line   = cmd_if.glyph_line;
        taken.bits   = cmd_if.glyph_bits;
        taken.fg     = cmd_if.fg_color;
        taken.bg     = cmd_if.bg_color;
        expand_cell(taken);
        items_taken <= items_taken + 1;
      end
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        cmd_if.valid <= 1'b0;
      end else if (cmd_pending.size() != 0) begin
        nxt = cmd_pending.pop_front();
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= nxt.opcode;
        cmd_if.cell_column <= nxt.col;
        cmd_if.cell_row    <= nxt.row;
        cmd_if.char_code   <= nxt.code;
        cmd_if.glyph_line  <= nxt.line;
        cmd_if.glyph_bits  <= nxt.bits;
        cmd_if.fg_color    <= nxt.fg;
        cmd_if.bg_color    <= nxt.bg;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          // end of burst: pick the next burst and the gap after this item
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  int unsigned rx_cycle, hold_left;
  bit          hold_done;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
      rx_cycle     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (!hold_done && items_taken >= HoldAt && cmd_if.valid) begin
        // long hold-off so the block backs up into its input
        hold_done    <= 1'b1;
        hold_left    <= HoldCycles;
        row_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        row_if.ready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0:    row_if.ready <= 1'b1;
          2'd1:    row_if.ready <= 1'($urandom_range(0, 1));
          2'd2:    row_if.ready <= (rx_cycle[1:0] == 2'd0);
          default: row_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------- result check ----------------

  always @(posedge clk_i) begin : check_proc
    pixel_row_t got, want;
    if (rst_ni && row_if.valid && row_if.ready) begin
      got.addr = row_if.row_address;
      got.pix  = {row_if.pixel_7, row_if.pixel_6, row_if.pixel_5, row_if.pixel_4,
                  row_if.pixel_3, row_if.pixel_2, row_if.pixel_1, row_if.pixel_0};
      got.last = row_if.last_row;
      if (rows_due.size() == 0) begin
        note_mismatch("row with no draw pending, address", '0, got.addr);
      end else begin
        want = rows_due.pop_front();
        if (got.addr !== want.addr) note_mismatch("row_address", want.addr, got.addr);
        for (int k = 0; k < NumPix; k++)
          if (got.pix[k] !== want.pix[k])
            note_mismatch($sformatf("pixel_%0d", k), want.pix[k], got.pix[k]);
        if (got.last !== want.last) note_mismatch("last_row", 32'(want.last), 32'(got.last));
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (row_if.valid && row_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- test sequence ----------------

  initial begin : main_proc
    logic [GBitsW-1:0] row_seed [8] = '{8'h00, 8'hff, 8'h80, 8'h01,
                                        8'haa, 8'h55, 8'h0f, 8'hf0};
    int unsigned target;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_FB_BASE;
    cfg_data_i         = '0;
    fb_base_q          = FB_BASE_RST;
    fb_pitch_q         = FB_PITCH_RST;
    fb_width_q         = FB_WIDTH_RST;
    fb_height_q        = FB_HEIGHT_RST;
    depth_q            = PIXEL_DEPTH_RST;
    font_q             = FONT_HEIGHT_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset settings: 80 x 30 cells, 16 rows, 32 bpp
    for (int ln = 0; ln < 16; ln++)
      queue_load(CodeW'(0), GLineW'(ln), (ln < 8) ? row_seed[ln] : GBitsW'($urandom));
    queue_draw(cell_at(0, 0, 0, 32'hffff_ffff, 32'h0000_0000));
    queue_draw(cell_at(79, 29, 0, 32'h0000_0000, 32'hffff_ffff));
    queue_draw(cell_at(80, 0, 0, $urandom, $urandom));
    queue_draw(cell_at(0, 30, 0, $urandom, $urandom));
    queue_draw(cell_at(511, 255, 0, $urandom, $urandom));
    queue_draw(cell_at(0, 0, CodeW'(GLYPH_COUNT_DEF), $urandom, $urandom));
    queue_draw(cell_at(0, 0, 16'hffff, $urandom, $urandom));
    // loads past the store must leave glyph zero intact
    queue_load(CodeW'(GLYPH_COUNT_DEF), GLineW'(0), 8'h5a);
    queue_load(16'hffff, GLineW'(31), 8'hff);
    queue_draw(cell_at(1, 1, 0, $urandom, $urandom));
    drain();

    for (int unsigned p = 1; p <= PhaseCount; p++) begin
      apply_settings(p);
      @(negedge clk_i);
      target = (p >= 4 && p <= 6) ? 15 : 50;
      while (cmd_pending.size() < target) queue_random_item();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
